FILE: design/tss_pkg.sv
// Shared types, codes and sizes for the timer slot scheduler.
package tss_pkg;

    localparam int SLOTS     = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int TAG_BITS  = 32;
    localparam int TIME_W    = 32;
    localparam int DELAY_W   = 24;
    localparam int ID_W      = 8;
    localparam int MAX_OUT   = 15;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);
    localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

    // Operation codes
    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_CANCEL   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_SCHEDULED = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_BAD_ID    = 3'd3;
    localparam logic [2:0] KIND_EXPIRED   = 3'd4;
    localparam logic [2:0] KIND_IDLE_TICK = 3'd5;

    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    // Command held steady for the whole sweep
    typedef struct packed {
        logic [1:0]         op;
        logic [TIME_W-1:0]  now;
        logic [DELAY_W-1:0] delay;
        tag_t               tag;
        logic [ID_W-1:0]    slot_id;
    } cmd_t;

    // Token handed from cell to cell
    typedef struct packed {
        logic                     valid;
        logic                     found;
        slot_t                    found_slot;
        cnt_t                     exp_count;
        logic                     best_valid;
        logic signed [TIME_W-1:0] best_left;
    } token_t;

endpackage

FILE: design/timer_slot_scheduler_core.sv
// Top level: command registers, the chain of slot cells and the result sequencer.
//
//  channel | dir | tuser     | tdata fields (lowest bit first)                    | tlast
//  s_*     | in  | operation | delay_ms, tag, slot_id                             | -
//  m_*     | out | kind      | slot, expired_tag, next_valid, next_delay, zero pad | last
//
//  A beat launches a token in the cycle after it is taken; the token crosses the SLOTS-1
//  cells, one cell per cycle, and its summary is registered from the tail of the chain.
//  A single result is registered as the sequencer returns to idle, and only then can the
//  next beat be taken. A tick with expiries then scans the cells once, one per cycle except
//  where an expired cell waits for a stalled output, emitting each expired slot.
//  aresetn clears every slot's live bit and the millisecond count.
//  A stalled m_tready holds the sequencer; s_tready is high only between items.
module timer_slot_scheduler_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,  // operation
    input  logic [63:0] s_tdata,  // delay_ms, tag, slot_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,  // kind
    output logic [63:0] m_tdata,  // slot, expired_tag, next_valid, next_delay, zero pad
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SINGLE,
        ST_SCAN
    } state_t;

    localparam int NCELL = tss_pkg::SLOTS;

    state_t                           state_reg, state_next;
    tss_pkg::cmd_t                    cmd_reg, cmd_next;
    logic [tss_pkg::TIME_W-1:0]       now_reg, now_next;
    logic                             start_reg, start_next;
    logic                             found_reg, found_next;
    tss_pkg::slot_t                   found_slot_reg, found_slot_next;
    tss_pkg::cnt_t                    exp_count_reg, exp_count_next;
    tss_pkg::cnt_t                    emitted_reg, emitted_next;
    tss_pkg::slot_t                   idx_reg, idx_next;
    logic                             nv_reg, nv_next;
    logic [tss_pkg::DELAY_W-1:0]      nd_reg, nd_next;
    logic                             m_valid_reg, m_valid_next;
    logic [2:0]                       m_kind_reg, m_kind_next;
    logic [3:0]                       m_slot_reg, m_slot_next;
    logic [31:0]                      m_tag_reg, m_tag_next;
    logic                             m_nv_reg, m_nv_next;
    logic [tss_pkg::DELAY_W-1:0]      m_nd_reg, m_nd_next;
    logic                             m_last_reg, m_last_next;

    tss_pkg::token_t                  tok [NCELL];
    logic [NCELL-1:0]                 exp_vec;
    tss_pkg::tag_t                    cell_tag [NCELL];
    tss_pkg::token_t                  tail;
    logic                             accept, out_free;

    // Launch token enters cell 1; slot 0 holds nothing
    always_comb begin
        tok[0]       = '0;
        tok[0].valid = start_reg;
    end
    assign exp_vec[0]  = 1'b0;
    assign cell_tag[0] = '0;

    // Build the row of slot cells
    for (genvar i = 1; i < NCELL; i++) begin : g_cell
        tss_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (tss_pkg::slot_t'(i)),
            .cmd      (cmd_reg),
            .tok_in   (tok[i-1]),
            .tok_out  (tok[i]),
            .expired  (exp_vec[i]),
            .tag_o    (cell_tag[i])
        );
    end
    assign tail = tok[NCELL-1];

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        now_next        = now_reg;
        start_next      = 1'b0;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        exp_count_next  = exp_count_reg;
        emitted_next    = emitted_reg;
        idx_next        = idx_reg;
        nv_next         = nv_reg;
        nd_next         = nd_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_kind_next     = m_kind_reg;
        m_slot_next     = m_slot_reg;
        m_tag_next      = m_tag_reg;
        m_nv_next       = m_nv_reg;
        m_nd_next       = m_nd_reg;
        m_last_next     = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                // Take the beat and start a sweep
                if (accept) begin
                    cmd_next.op      = s_tuser;
                    cmd_next.delay   = s_tdata[23:0];
                    cmd_next.tag     = tss_pkg::tag_t'(s_tdata[55:24]);
                    cmd_next.slot_id = s_tdata[63:56];
                    cmd_next.now     = (s_tuser == tss_pkg::OP_TICK) ?
                                       now_reg + 1'b1 : now_reg;
                    now_next         = cmd_next.now;
                    start_next       = 1'b1;
                    state_next       = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                // Capture the sweep summary at the tail of the chain
                if (tail.valid) begin
                    found_next      = tail.found;
                    found_slot_next = tail.found_slot;
                    exp_count_next  = tail.exp_count;
                    nv_next         = tail.best_valid;
                    if (!tail.best_valid || tail.best_left <= 0) begin
                        nd_next = '0;
                    end else if (tail.best_left > $signed({8'd0, tss_pkg::DELAY_MAX})) begin
                        nd_next = tss_pkg::DELAY_MAX;
                    end else begin
                        nd_next = tail.best_left[tss_pkg::DELAY_W-1:0];
                    end
                    emitted_next = '0;
                    idx_next     = tss_pkg::slot_t'(1);
                    if (cmd_reg.op == tss_pkg::OP_TICK && tail.exp_count != '0) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_SINGLE;
                    end
                end
            end
            ST_SINGLE: begin
                // Emit the one result of this item
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_tag_next   = '0;
                    m_slot_next  = '0;
                    m_nv_next    = nv_reg;
                    m_nd_next    = nd_reg;
                    m_last_next  = 1'b1;
                    case (cmd_reg.op)
                        tss_pkg::OP_SCHEDULE: begin
                            m_kind_next = found_reg ? tss_pkg::KIND_SCHEDULED
                                                    : tss_pkg::KIND_FULL;
                            m_slot_next = found_reg ? 4'(found_slot_reg) : 4'd0;
                        end
                        tss_pkg::OP_CANCEL: begin
                            if ({1'b0, cmd_reg.slot_id} >= 9'(tss_pkg::SLOTS)) begin
                                m_kind_next = tss_pkg::KIND_BAD_ID;
                            end else begin
                                m_kind_next = tss_pkg::KIND_CANCELLED;
                                m_slot_next = 4'(cmd_reg.slot_id);
                            end
                        end
                        default: begin
                            m_kind_next = tss_pkg::KIND_IDLE_TICK;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // Walk the cells in ascending order, emit each expired one
                if (exp_vec[idx_reg]) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = tss_pkg::KIND_EXPIRED;
                        m_slot_next  = 4'(idx_reg);
                        m_tag_next   = 32'(cell_tag[idx_reg]);
                        m_nv_next    = nv_reg;
                        m_nd_next    = nd_reg;
                        m_last_next  = (emitted_reg + 1'b1 == exp_count_reg);
                        emitted_next = emitted_reg + 1'b1;
                        idx_next     = idx_reg + 1'b1;
                        if (emitted_reg + 1'b1 == exp_count_reg) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            now_reg     <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            now_reg        <= now_next;
            start_reg      <= start_next;
            found_reg      <= found_next;
            found_slot_reg <= found_slot_next;
            exp_count_reg  <= exp_count_next;
            emitted_reg    <= emitted_next;
            idx_reg        <= idx_next;
            nv_reg         <= nv_next;
            nd_reg         <= nd_next;
            m_valid_reg    <= m_valid_next;
            m_kind_reg     <= m_kind_next;
            m_slot_reg     <= m_slot_next;
            m_tag_reg      <= m_tag_next;
            m_nv_reg       <= m_nv_next;
            m_nd_reg       <= m_nd_next;
            m_last_reg     <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {3'd0, m_nd_reg, m_nv_reg, m_tag_reg, m_slot_reg};
    assign m_tlast  = m_last_reg;

endmodule

FILE: design/tss_cell.sv
// One timer slot cell: holds a slot's state and updates the passing token.
module tss_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tss_pkg::slot_t        cell_idx,
    input  tss_pkg::cmd_t         cmd,
    input  tss_pkg::token_t       tok_in,
    output tss_pkg::token_t       tok_out,
    output logic                  expired,
    output tss_pkg::tag_t         tag_o
);

    logic                             live_reg, live_next;
    logic                             exp_reg, exp_next;
    logic [tss_pkg::TIME_W-1:0]       deadline_reg, deadline_next;
    tss_pkg::tag_t                    tag_reg, tag_next;
    tss_pkg::token_t                  tok_reg, tok_next;
    logic signed [tss_pkg::TIME_W-1:0] left_cur, post_left;
    logic                             claim, expire_now;

    // Wrap-safe remaining time against the current millisecond count
    assign left_cur = $signed(deadline_reg - cmd.now);

    always_comb begin
        live_next     = live_reg;
        exp_next      = exp_reg;
        deadline_next = deadline_reg;
        tag_next      = tag_reg;
        tok_next      = tok_in;
        claim         = 1'b0;
        expire_now    = 1'b0;
        post_left     = left_cur;
        if (tok_in.valid) begin
            case (cmd.op)
                tss_pkg::OP_SCHEDULE: begin
                    claim = !live_reg && !tok_in.found;
                end
                tss_pkg::OP_CANCEL: begin
                    if (cmd.slot_id == tss_pkg::ID_W'(cell_idx)) begin
                        live_next = 1'b0;
                    end
                end
                tss_pkg::OP_TICK: begin
                    expire_now = live_reg && (left_cur <= 0) &&
                                 (tok_in.exp_count < tss_pkg::cnt_t'(tss_pkg::MAX_OUT));
                end
                default: begin
                end
            endcase
            // Claim this slot as the lowest free one
            if (claim) begin
                live_next           = 1'b1;
                deadline_next       = cmd.now + tss_pkg::TIME_W'(cmd.delay);
                tag_next            = cmd.tag;
                post_left           = $signed(tss_pkg::TIME_W'(cmd.delay));
                tok_next.found      = 1'b1;
                tok_next.found_slot = cell_idx;
            end
            // Retire an expired slot and count it
            exp_next = expire_now;
            if (expire_now) begin
                live_next          = 1'b0;
                tok_next.exp_count = tok_in.exp_count + 1'b1;
            end
            // Fold this slot into the running minimum, ties keep the lower slot
            if (live_next && (!tok_in.best_valid || post_left < tok_in.best_left)) begin
                tok_next.best_valid = 1'b1;
                tok_next.best_left  = post_left;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg      <= 1'b0;
            exp_reg       <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            live_reg     <= live_next;
            exp_reg      <= exp_next;
            deadline_reg <= deadline_next;
            tag_reg      <= tag_next;
            tok_reg      <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign expired = exp_reg;
    assign tag_o   = tag_reg;

endmodule

FILE: design/tss_checker.sv
// Port-level checks for the timer slot scheduler, bound to the top level.
module tss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [2:0]  m_tuser,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser) && $stable(m_tdata) &&
                                  $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Take one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again before the item finished");

    // Only expiries come in runs; every other kind ends its item
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != tss_pkg::KIND_EXPIRED |-> m_tlast)
        else $error("non-expiry result not marked last");

    // Report no delay when nothing is pending
    a_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[36] |-> m_tdata[60:37] == '0)
        else $error("delay reported with no pending timer");

    // Name a real slot on every expiry
    a_exp_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == tss_pkg::KIND_EXPIRED |-> m_tdata[3:0] != 4'd0)
        else $error("expiry reported for slot zero");

endmodule

bind timer_slot_scheduler_core tss_checker u_tss_checker (.*);

FILE: test/tss_result_checker.sv
// Checker for the timer slot scheduler: predicts every result beat and compares it.
module tss_result_checker
    import tss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [2:0]  m_tuser,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding
);

    typedef struct {
        logic [2:0]         kind;
        slot_t              slot;
        logic [31:0]        expired_tag;
        logic               next_valid;
        logic [DELAY_W-1:0] next_delay;
        logic               last;
    } timer_result_t;

    // Shadow copy of the timer table
    logic              live_slot [SLOTS];
    logic [TIME_W-1:0] slot_deadline_q [SLOTS];
    tag_t              slot_tag_q [SLOTS];
    logic [TIME_W-1:0] now_ms;

    timer_result_t due_results[$];
    int            fail_count;
    int            due_count;
    int            beat_no;

    assign mismatches  = fail_count;
    assign outstanding = due_count;

    // Signed distance from now to a deadline, safe across wrap
    function automatic logic signed [TIME_W-1:0] time_left(input logic [TIME_W-1:0] deadline);
        return signed'(deadline - now_ms);
    endfunction

    function automatic timer_result_t make_result(input logic [2:0] kind, input slot_t slot,
                                                  input logic [31:0] tg);
        timer_result_t r;
        r.kind        = kind;
        r.slot        = slot;
        r.expired_tag = tg;
        r.next_valid  = 1'b0;
        r.next_delay  = '0;
        r.last        = 1'b0;
        return r;
    endfunction

    // Apply one command to the shadow table and queue the result beats it causes
    task automatic advance_timer_table(input logic [1:0] op_in, input logic [63:0] beat);
        logic [1:0]               op;
        logic [DELAY_W-1:0]       dly;
        tag_t                     tg;
        logic [ID_W-1:0]          id;
        timer_result_t            res[$];
        timer_result_t            r;
        int                       s;
        int                       best;
        logic signed [TIME_W-1:0] best_left;
        logic signed [TIME_W-1:0] left;
        logic                     nv;
        logic [DELAY_W-1:0]       nd;
        op  = op_in;
        dly = beat[23:0];
        tg  = beat[55:24];
        id  = beat[63:56];
        case (op)
            OP_SCHEDULE: begin
                s = 1;
                while (s < SLOTS && live_slot[s]) s++;
                if (s >= SLOTS) begin
                    res.push_back(make_result(KIND_FULL, '0, '0));
                end else begin
                    live_slot[s]       = 1'b1;
                    slot_deadline_q[s] = now_ms + TIME_W'(dly);
                    slot_tag_q[s]      = tg;
                    res.push_back(make_result(KIND_SCHEDULED, slot_t'(s), '0));
                end
            end
            OP_CANCEL: begin
                if (id >= SLOTS) begin
                    res.push_back(make_result(KIND_BAD_ID, '0, '0));
                end else begin
                    live_slot[id[SLOT_W-1:0]] = 1'b0;
                    res.push_back(make_result(KIND_CANCELLED, id[SLOT_W-1:0], '0));
                end
            end
            OP_TICK: begin
                now_ms = now_ms + 1'b1;
                for (s = 1; s < SLOTS && res.size() < MAX_OUT; s++) begin
                    if (live_slot[s] && time_left(slot_deadline_q[s]) <= 0) begin
                        live_slot[s] = 1'b0;
                        res.push_back(make_result(KIND_EXPIRED, slot_t'(s),
                                                  32'(slot_tag_q[s])));
                    end
                end
                if (res.size() == 0)
                    res.push_back(make_result(KIND_IDLE_TICK, '0, '0));
            end
            default: begin
                // unused code: no state change, a single idle result
                res.push_back(make_result(KIND_IDLE_TICK, '0, '0));
            end
        endcase

        // Earliest pending deadline; the lowest slot wins a tie
        best      = -1;
        best_left = '0;
        for (s = 1; s < SLOTS; s++) begin
            if (live_slot[s]) begin
                left = time_left(slot_deadline_q[s]);
                if (best < 0 || left < best_left) begin
                    best      = s;
                    best_left = left;
                end
            end
        end
        nv = (best >= 0);
        if (best < 0 || best_left <= 0)
            nd = '0;
        else if (best_left > signed'({8'd0, DELAY_MAX}))
            nd = DELAY_MAX;
        else
            nd = best_left[DELAY_W-1:0];

        for (int k = 0; k < res.size(); k++) begin
            r            = res[k];
            r.next_valid = nv;
            r.next_delay = nd;
            r.last       = (k == res.size() - 1);
            due_results.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("result beat %0d: %s is %0h, expected %0h", beat_no, field, got, want);
        fail_count++;
    endtask

    // Predict on each accepted command, compare on each accepted result
    always @(posedge aclk) begin
        timer_result_t want;
        if (!aresetn) begin
            for (int s = 0; s < SLOTS; s++) live_slot[s] = 1'b0;
            now_ms = '0;
            due_results.delete();
            due_count  = 0;
            fail_count = 0;
            beat_no    = 0;
        end else begin
            if (s_tvalid && s_tready)
                advance_timer_table(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected beat, m_tdata", m_tdata, '0);
                end else begin
                    want = due_results.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch("kind", m_tuser, want.kind);
                    if (m_tdata[3:0] !== want.slot)
                        report_mismatch("slot", m_tdata[3:0], want.slot);
                    if (m_tdata[35:4] !== want.expired_tag)
                        report_mismatch("expired_tag", m_tdata[35:4], want.expired_tag);
                    if (m_tdata[36] !== want.next_valid)
                        report_mismatch("next_valid", m_tdata[36], want.next_valid);
                    if (m_tdata[60:37] !== want.next_delay)
                        report_mismatch("next_delay", m_tdata[60:37], want.next_delay);
                    if (m_tlast !== want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
                beat_no++;
            end
            due_count = due_results.size();
        end
    end

endmodule

FILE: test/tb.sv
// Testbench top: drives commands and result backpressure, then gives the verdict.
module tb;
    import tss_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 80;
    localparam int         RANDOM_ITEMS = 435;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser  = '0;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [2:0]  m_tuser;
    logic [63:0] m_tdata;
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int rx_hold     = 0;
    bit no_gaps     = 1'b0;

    timer_slot_scheduler_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    tss_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: hold tready low for a random number of cycles after each beat
    always @(posedge aclk) begin
        int hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tvalid && m_tready) begin
            hold = no_gaps ? 0 : $urandom_range(0, 7);
            m_tready <= (hold == 0);
            rx_hold  <= (hold == 0) ? 0 : hold - 1;
        end else if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one command beat after a random gap and wait until it is taken
    task automatic send_command(input logic [1:0] op, input logic [DELAY_W-1:0] dly,
                                input logic [31:0] tg, input logic [ID_W-1:0] id);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {id, tg, dly};
        s_tvalid <= 1'b1;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    initial begin
        int pick;
        logic [DELAY_W-1:0] dly;
        logic [ID_W-1:0]    id;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle tick, unused code, cancel edge cases
        send_command(OP_TICK, '0, '0, '0);
        send_command(OP_UNUSED, '1, '1, '1);
        send_command(OP_CANCEL, '0, '0, 8'd0);
        send_command(OP_CANCEL, '0, '0, 8'd255);
        send_command(OP_CANCEL, '0, '0, 8'd16);
        send_command(OP_CANCEL, '0, '0, 8'd15);
        // Fill the table: zero delay, maximum delay, then short delays
        send_command(OP_SCHEDULE, '0, 32'hFFFF_FFFF, '0);
        send_command(OP_SCHEDULE, DELAY_MAX, 32'h0000_0000, '0);
        for (int s = 3; s < SLOTS; s++)
            send_command(OP_SCHEDULE, 24'd1, $urandom, '0);
        // Table full, then a tick that expires all but the long one
        send_command(OP_SCHEDULE, 24'd5, $urandom, '0);
        send_command(OP_TICK, '0, '0, '0);
        send_command(OP_CANCEL, '0, '0, 8'd2);
        send_command(OP_TICK, '0, '0, '0);

        // Random: mostly short timers that expire under ticks, some long ones
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 48 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                dly = ($urandom_range(0, 9) == 0) ? DELAY_W'($urandom)
                                                  : DELAY_W'($urandom_range(0, 12));
                send_command(OP_SCHEDULE, dly, $urandom, ID_W'($urandom));
            end else if (pick < 58) begin
                id = ($urandom_range(0, 7) == 0) ? ID_W'($urandom_range(0, 255))
                                                 : ID_W'($urandom_range(1, SLOTS - 1));
                send_command(OP_CANCEL, DELAY_W'($urandom), $urandom, id);
            end else if (pick < 97) begin
                send_command(OP_TICK, DELAY_W'($urandom), $urandom, ID_W'($urandom));
            end else begin
                send_command(OP_UNUSED, DELAY_W'($urandom), $urandom, ID_W'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for stray beats
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
